// ===== rtl/hash_timestamp_record_packer_assert.svh =====
// ------------------------------------------------------------------------
// Assertion macros for the hash timestamp record packer
// Shared property forms, clocked on aclk and disabled during reset.
// ------------------------------------------------------------------------
`ifndef HASH_TIMESTAMP_RECORD_PACKER_ASSERT_SVH
`define HASH_TIMESTAMP_RECORD_PACKER_ASSERT_SVH

// Same-cycle implication.
`define HTP_ASSERT_NOW(lbl, a, b, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (a) |-> (b)) \
        else $error(msg);

// Next-cycle implication.
`define HTP_ASSERT_NEXT(lbl, a, b, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (a) |=> (b)) \
        else $error(msg);

`endif

// ===== rtl/htp_pkg.sv =====
// ------------------------------------------------------------------------
// Hash timestamp record packer package
// Shared constants and the queue entry type.
// ------------------------------------------------------------------------
package htp_pkg;

    localparam int HEADER_BYTES     = 12;
    localparam int MAX_PACKET_BYTES = 1024;
    localparam logic [31:0] USEC_PER_SEC = 32'd1000000;

    localparam logic [15:0] SCALE_RESET = 16'd100;
    localparam logic [2:0]  LEN_RESET   = 3'd2;
    localparam logic [2:0]  LEN_MAX     = 3'd4;

    localparam logic REG_TIME_SCALE   = 1'b0;
    localparam logic REG_STAMP_LENGTH = 1'b1;

    localparam logic KIND_HEADER = 1'b0;
    localparam logic KIND_RECORD = 1'b1;

    // One classified capture event, as it waits between front and back.
    typedef struct packed {
        logic [31:0] seconds;
        logic [19:0] microseconds;
        logic [31:0] hash;
        logic        direction;
        logic [2:0]  len;    // stamp length, clamped to 0..4
        logic [15:0] scale;  // time scale, zero replaced by one
    } item_t;

endpackage

// ===== rtl/htp_front.sv =====
// ------------------------------------------------------------------------
// Packer front end
// Accepts capture events, normalizes the stamp settings with each one and
// holds them in a two-entry queue for the back end.
// ------------------------------------------------------------------------
module htp_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [31:0]          s_capture_seconds,
    input  logic [19:0]          s_capture_microseconds,
    input  logic [31:0]          s_packet_hash,
    input  logic                 s_flow_direction,
    input  logic [15:0]          time_scale,
    input  logic [2:0]           stamp_length,
    output logic                 q_valid,
    output htp_pkg::item_t       q_item,
    input  logic                 q_pop
);

    htp_pkg::item_t entry_reg [2];
    logic           wr_ptr_reg;
    logic           rd_ptr_reg;
    logic [1:0]     count_reg;
    htp_pkg::item_t in_item;
    logic           push;

    always_comb begin
        in_item.seconds      = s_capture_seconds;
        in_item.microseconds = s_capture_microseconds;
        in_item.hash         = s_packet_hash;
        in_item.direction    = s_flow_direction;
        in_item.len          = (stamp_length > htp_pkg::LEN_MAX) ? htp_pkg::LEN_MAX
                                                                 : stamp_length;
        in_item.scale        = (time_scale == 16'd0) ? 16'd1 : time_scale;
    end

    assign s_ready = (count_reg != 2'd2);
    assign push    = s_valid && s_ready;
    assign q_valid = (count_reg != 2'd0);
    assign q_item  = entry_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= in_item;
        end
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (q_pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_reg + 2'(push) - 2'(q_pop);
        end
    end

endmodule

// ===== rtl/htp_div.sv =====
// ------------------------------------------------------------------------
// Packer divider
// Restoring divider, 32-bit dividend by 16-bit divisor, one quotient bit
// per cycle.
// ------------------------------------------------------------------------
module htp_div (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [15:0] divisor,
    output logic        done,
    output logic [31:0] quotient
);

    logic [31:0] quo_reg;
    logic [16:0] rem_reg;
    logic [15:0] dsr_reg;
    logic [5:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [16:0] rem_shift;
    logic        take;

    assign rem_shift = {rem_reg[15:0], quo_reg[31]};
    assign take      = (rem_shift >= {1'b0, dsr_reg});
    assign done      = done_reg;
    assign quotient  = quo_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 6'd0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= 6'd0;
                quo_reg  <= dividend;
                rem_reg  <= 17'd0;
                dsr_reg  <= divisor;
            end else if (busy_reg) begin
                rem_reg <= take ? (rem_shift - {1'b0, dsr_reg}) : rem_shift;
                quo_reg <= {quo_reg[30:0], take};
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'd31) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

// ===== rtl/htp_back.sv =====
// ------------------------------------------------------------------------
// Packer back end
// Takes queued events, works out the stamp, decides on packet starts and
// delivers header and record items through an output register.
// ------------------------------------------------------------------------
`include "hash_timestamp_record_packer_assert.svh"

module htp_back #(
    parameter int MAX_PACKET_BYTES = htp_pkg::MAX_PACKET_BYTES
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           q_valid,
    input  htp_pkg::item_t q_item,
    output logic           q_pop,
    input  logic           m_ready,
    output logic           m_valid,
    output logic           m_item_kind,
    output logic           m_closes_previous,
    output logic [2:0]     m_stamp_code,
    output logic [31:0]    m_header_seconds,
    output logic [19:0]    m_header_microseconds,
    output logic [31:0]    m_record_hash,
    output logic [63:0]    m_record_stamp,
    output logic [3:0]     m_record_stamp_bytes,
    output logic           m_last
);

    localparam logic [15:0] FLUSH_LIMIT = 16'(MAX_PACKET_BYTES - htp_pkg::HEADER_BYTES);
    localparam logic [15:0] HDR_BYTES   = 16'(htp_pkg::HEADER_BYTES);

    typedef enum logic [2:0] {
        S_IDLE, S_PREP, S_MUL, S_DIV1, S_DIV2, S_EMIT
    } state_t;

    state_t         st_reg;
    htp_pkg::item_t it_reg;
    logic           open_reg;
    logic           flush_reg;
    logic [31:0]    diff_reg;
    logic [31:0]    pv_usec_reg;
    logic [31:0]    t_reg;
    logic [31:0]    q1_reg;
    logic [31:0]    offset_reg;
    logic [15:0]    fill_reg;
    logic [31:0]    prev_sec_reg;
    logic [19:0]    prev_usec_reg;

    logic           m_valid_reg;
    logic           m_kind_reg;
    logic           m_closes_reg;
    logic [2:0]     m_code_reg;
    logic [31:0]    m_hsec_reg;
    logic [19:0]    m_husec_reg;
    logic [31:0]    m_hash_reg;
    logic [63:0]    m_stamp_reg;
    logic [3:0]     m_nbytes_reg;
    logic           m_last_reg;

    logic           div_start;
    logic [31:0]    div_dividend;
    logic           div_done;
    logic [31:0]    div_quo;

    logic           open_now;
    logic [15:0]    fill_base;
    logic [31:0]    offset_next;
    logic           fits;
    logic [31:0]    off_eff;
    logic [63:0]    stamp;
    logic [3:0]     nbytes;
    logic           out_free;

    htp_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (it_reg.scale),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign div_start    = ((st_reg == S_MUL) && (it_reg.len != 3'd0))
                       || ((st_reg == S_DIV1) && div_done);
    assign div_dividend = (st_reg == S_MUL) ? (diff_reg * htp_pkg::USEC_PER_SEC
                                               + 32'(it_reg.microseconds))
                                            : pv_usec_reg;

    assign open_now    = (fill_reg == 16'd0);
    assign fill_base   = open_now ? HDR_BYTES : fill_reg;
    assign offset_next = q1_reg - div_quo;
    assign q_pop       = (st_reg == S_IDLE) && q_valid;
    assign out_free    = !m_valid_reg || m_ready;

    always_comb begin
        case (it_reg.len)
            3'd1:    fits = (offset_next[31:7] == 25'd0);
            3'd2:    fits = (offset_next[31:15] == 17'd0);
            3'd3:    fits = (offset_next[31:23] == 9'd0);
            default: fits = !offset_next[31];
        endcase
    end

    assign off_eff = flush_reg ? 32'd0 : offset_reg;

    always_comb begin
        case (it_reg.len)
            3'd0: begin
                stamp  = {it_reg.direction, it_reg.seconds[30:0], 12'd0,
                          it_reg.microseconds};
                nbytes = 4'd8;
            end
            3'd1: begin
                stamp  = {56'd0, it_reg.direction, off_eff[6:0]};
                nbytes = 4'd1;
            end
            3'd2: begin
                stamp  = {48'd0, it_reg.direction, off_eff[14:0]};
                nbytes = 4'd2;
            end
            3'd3: begin
                stamp  = {40'd0, it_reg.direction, off_eff[22:0]};
                nbytes = 4'd3;
            end
            default: begin
                stamp  = {32'd0, it_reg.direction, off_eff[30:0]};
                nbytes = 4'd4;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg        <= S_IDLE;
            m_valid_reg   <= 1'b0;
            fill_reg      <= 16'd0;
            prev_sec_reg  <= 32'd0;
            prev_usec_reg <= 20'd0;
            open_reg      <= 1'b0;
            flush_reg     <= 1'b0;
        end else begin
            if (m_ready && (st_reg != S_EMIT)) begin
                m_valid_reg <= 1'b0;
            end
            case (st_reg)
                S_IDLE: begin
                    if (q_valid) begin
                        it_reg <= q_item;
                        st_reg <= S_PREP;
                    end
                end
                S_PREP: begin
                    open_reg    <= open_now;
                    flush_reg   <= (fill_base > FLUSH_LIMIT);
                    diff_reg    <= it_reg.seconds
                                 - (open_now ? it_reg.seconds : prev_sec_reg);
                    pv_usec_reg <= 32'(open_now ? it_reg.microseconds : prev_usec_reg);
                    st_reg      <= S_MUL;
                end
                S_MUL: begin
                    st_reg <= (it_reg.len == 3'd0) ? S_EMIT : S_DIV1;
                end
                S_DIV1: begin
                    if (div_done) begin
                        q1_reg <= div_quo;
                        st_reg <= S_DIV2;
                    end
                end
                S_DIV2: begin
                    if (div_done) begin
                        offset_reg <= offset_next;
                        flush_reg  <= flush_reg || !fits;
                        st_reg     <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        if (open_reg || flush_reg) begin
                            m_kind_reg   <= htp_pkg::KIND_HEADER;
                            m_closes_reg <= !open_reg;
                            m_code_reg   <= it_reg.len;
                            m_hsec_reg   <= it_reg.seconds;
                            m_husec_reg  <= it_reg.microseconds;
                            m_hash_reg   <= 32'd0;
                            m_stamp_reg  <= 64'd0;
                            m_nbytes_reg <= 4'd0;
                            m_last_reg   <= 1'b0;
                            if (open_reg) begin
                                open_reg <= 1'b0;
                            end else begin
                                // The first record of a new packet has offset zero.
                                flush_reg  <= 1'b0;
                                fill_reg   <= HDR_BYTES;
                                offset_reg <= 32'd0;
                            end
                            if (open_reg) begin
                                fill_reg <= HDR_BYTES;
                            end
                        end else begin
                            m_kind_reg   <= htp_pkg::KIND_RECORD;
                            m_closes_reg <= 1'b0;
                            m_code_reg   <= 3'd0;
                            m_hsec_reg   <= 32'd0;
                            m_husec_reg  <= 20'd0;
                            m_hash_reg   <= it_reg.hash;
                            m_stamp_reg  <= stamp;
                            m_nbytes_reg <= nbytes;
                            m_last_reg   <= 1'b1;
                            fill_reg     <= fill_reg + 16'd4 + 16'(nbytes);
                            st_reg       <= S_IDLE;
                        end
                    end
                end
                default: st_reg <= S_IDLE;
            endcase
            // Previous time follows every offset-mode event, and every packet
            // start in absolute mode.
            if ((st_reg == S_EMIT) && out_free && !open_reg && !flush_reg) begin
                if ((it_reg.len != 3'd0) || (fill_reg == HDR_BYTES)) begin
                    prev_sec_reg  <= it_reg.seconds;
                    prev_usec_reg <= it_reg.microseconds;
                end
            end
        end
    end

    assign m_valid               = m_valid_reg;
    assign m_item_kind           = m_kind_reg;
    assign m_closes_previous     = m_closes_reg;
    assign m_stamp_code          = m_code_reg;
    assign m_header_seconds      = m_hsec_reg;
    assign m_header_microseconds = m_husec_reg;
    assign m_record_hash         = m_hash_reg;
    assign m_record_stamp        = m_stamp_reg;
    assign m_record_stamp_bytes  = m_nbytes_reg;
    assign m_last                = m_last_reg;

    `HTP_ASSERT_NOW(a_record_last, m_valid_reg && m_kind_reg, m_last_reg, "record without last")
    `HTP_ASSERT_NOW(a_header_not_last, m_valid_reg && !m_kind_reg, !m_last_reg, "header with last")
    `HTP_ASSERT_NOW(a_div_done_state, div_done, st_reg == S_DIV1 || st_reg == S_DIV2, "stray divide")
    `HTP_ASSERT_NEXT(a_pop_prep, q_pop, st_reg == S_PREP, "pop without prep")

endmodule

// ===== rtl/hash_timestamp_record_packer.sv =====
// ------------------------------------------------------------------------
// Hash timestamp record packer
// Packs per-packet hash records with absolute or offset stamps into
// report packets, emitting a header item at the start of each packet.
// ------------------------------------------------------------------------
// Each accepted capture event yields a record item, preceded by a header
// item when a report packet is opened. In absolute mode (stamp_length 0) an
// event passes the back end's idle, prep, multiply and emit states. In
// offset mode the stamp needs two 32-bit by 16-bit divisions by time_scale
// on a shared one-bit-per-cycle divider. A header item is emitted ahead of
// its record, and a result that waits for its transfer holds the back end
// until it completes. A two-entry queue sits between the front end and the
// back end, so new transfers are taken while an event is being worked on
// and the queue has room, and an output register holds each result until
// its transfer completes.
module hash_timestamp_record_packer #(
    parameter int MAX_PACKET_BYTES = htp_pkg::MAX_PACKET_BYTES
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration port: time_scale at 0x0, stamp_length at 0x4.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Capture event channel.
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_capture_seconds,
    input  logic [19:0] s_capture_microseconds,
    input  logic [31:0] s_packet_hash,
    input  logic        s_flow_direction,
    // Result item channel.
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_item_kind,
    output logic        m_closes_previous,
    output logic [2:0]  m_stamp_code,
    output logic [31:0] m_header_seconds,
    output logic [19:0] m_header_microseconds,
    output logic [31:0] m_record_hash,
    output logic [63:0] m_record_stamp,
    output logic [3:0]  m_record_stamp_bytes,
    output logic        m_last
);

    logic [15:0]    time_scale_reg;
    logic [2:0]     stamp_length_reg;
    logic           q_valid;
    logic           q_pop;
    htp_pkg::item_t q_item;

    // The register file decodes on the word address bit only.
    assign pready = 1'b1;
    assign prdata = (paddr[2] == htp_pkg::REG_STAMP_LENGTH) ? {29'd0, stamp_length_reg}
                                                            : {16'd0, time_scale_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            time_scale_reg   <= htp_pkg::SCALE_RESET;
            stamp_length_reg <= htp_pkg::LEN_RESET;
        end else if (psel && penable && pwrite) begin
            if (paddr[2] == htp_pkg::REG_TIME_SCALE) begin
                time_scale_reg <= pwdata[15:0];
            end else begin
                stamp_length_reg <= pwdata[2:0];
            end
        end
    end

    // The front end snapshots the normalized settings with each event.
    htp_front u_front (
        .aclk                   (aclk),
        .aresetn                (aresetn),
        .s_valid                (s_valid),
        .s_ready                (s_ready),
        .s_capture_seconds      (s_capture_seconds),
        .s_capture_microseconds (s_capture_microseconds),
        .s_packet_hash          (s_packet_hash),
        .s_flow_direction       (s_flow_direction),
        .time_scale             (time_scale_reg),
        .stamp_length           (stamp_length_reg),
        .q_valid                (q_valid),
        .q_item                 (q_item),
        .q_pop                  (q_pop)
    );

    // The back end keeps the packet fill and the previous stamp time.
    htp_back #(
        .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
    ) u_back (
        .aclk                  (aclk),
        .aresetn               (aresetn),
        .q_valid               (q_valid),
        .q_item                (q_item),
        .q_pop                 (q_pop),
        .m_ready               (m_ready),
        .m_valid               (m_valid),
        .m_item_kind           (m_item_kind),
        .m_closes_previous     (m_closes_previous),
        .m_stamp_code          (m_stamp_code),
        .m_header_seconds      (m_header_seconds),
        .m_header_microseconds (m_header_microseconds),
        .m_record_hash         (m_record_hash),
        .m_record_stamp        (m_record_stamp),
        .m_record_stamp_bytes  (m_record_stamp_bytes),
        .m_last                (m_last)
    );

endmodule
